// ===== rtl/lph_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lph_pkg
// Types and constants shared by the linear-probe hash table controller,
// datapath and top level.
// ----------------------------------------------------------------------------
package lph_pkg;

    localparam int KEY_W        = 32;
    localparam int CMD_W        = 2;
    localparam int SLOT_W       = 6;
    localparam int HOME_SHIFT   = 2;
    // Remainder unit takes four key bits per step
    localparam int HOME_DIGIT_W = 4;
    localparam int HOME_STEPS   = KEY_W / HOME_DIGIT_W;

    // Command codes; any other code is a lookup
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
    } lph_in_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              found;
        logic              written;
        logic              table_full;
    } lph_out_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_HOME,
        ST_PRD,
        ST_PCMP,
        ST_GRD,
        ST_GCHK,
        ST_GHOME,
        ST_GEND,
        ST_DONE
    } lph_state_t;

    typedef enum logic [1:0] {
        PTR_HOLD,
        PTR_INC,
        PTR_HOME
    } lph_ptr_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_ZERO,
        CNT_ONE,
        CNT_INC
    } lph_cnt_op_t;

    typedef enum logic [1:0] {
        WR_CLEAR,
        WR_INSERT,
        WR_MOVE,
        WR_SHUT
    } lph_wr_sel_t;

    typedef struct packed {
        lph_ptr_op_t ptr_op;
        lph_cnt_op_t cnt_op;
        logic        gap_load;
        logic        home_start;
        logic        home_from_rd;
        logic        req_load;
        logic        wr_en;
        lph_wr_sel_t wr_sel;
        logic        res_load;
        logic        res_slot_ptr;
        logic        res_found;
        logic        res_written;
        logic        res_full;
        logic        out_load;
    } lph_ctrl_t;

    typedef struct packed {
        logic clear_last;
        logic key_zero;
        logic is_insert;
        logic is_erase;
        logic home_done;
        logic match;
        logic empty;
        logic cnt_last;
        logic stays;
        logic out_busy;
    } lph_status_t;

endpackage
`default_nettype wire

// ===== rtl/lph_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lph_dpath
// Key store, probe pointer, gap pointer, home-slot remainder unit and the
// result and output registers of the hash table.
// ----------------------------------------------------------------------------
module lph_dpath
    import lph_pkg::*;
#(
    parameter int TABLE_SIZE = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire lph_ctrl_t   ctrl,
    output lph_status_t      status,
    input  wire lph_in_t     s_data,
    input  wire logic        m_ready,
    output logic             m_valid,
    output lph_out_t         m_data
);

    localparam int IDX_W   = $clog2(TABLE_SIZE);
    localparam int REM_W   = IDX_W + 1;
    localparam int EXT_W   = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam int HCNT_W  = $clog2(HOME_STEPS + 1);
    localparam bit IS_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
    localparam logic [REM_W-1:0] SIZE_R   = REM_W'(TABLE_SIZE);

    logic [KEY_W-1:0]  mem [TABLE_SIZE];
    logic [KEY_W-1:0]  rd_data_reg;

    logic [IDX_W-1:0]  ptr_reg, ptr_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0]  gap_reg, gap_next;
    logic [KEY_W-1:0]  key_reg;
    logic [CMD_W-1:0]  cmd_reg;

    logic [KEY_W-1:0]  home_src_reg, home_src_next;
    logic [REM_W-1:0]  home_rem_reg, home_rem_next;
    logic [HCNT_W-1:0] home_cnt_reg, home_cnt_next;

    lph_out_t          res_reg, res_next;
    lph_out_t          out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic [IDX_W-1:0]  ptr_inc;
    logic [IDX_W-1:0]  home_val;
    logic [KEY_W-1:0]  home_in;
    logic [KEY_W-1:0]  home_shifted;
    logic [REM_W-1:0]  step_rem;
    logic [KEY_W-1:0]  step_src;
    logic [IDX_W-1:0]  wr_addr;
    logic [KEY_W-1:0]  wr_data;
    logic [EXT_W-1:0]  slot_ext;
    logic              stays;

    assign ptr_inc  = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + 1'b1;
    assign home_val = home_rem_reg[IDX_W-1:0];

    always_comb begin
        ptr_next = ptr_reg;
        case (ctrl.ptr_op)
            PTR_INC:  ptr_next = ptr_inc;
            PTR_HOME: ptr_next = home_val;
            default:  ptr_next = ptr_reg;
        endcase
    end

    always_comb begin
        cnt_next = cnt_reg;
        case (ctrl.cnt_op)
            CNT_ZERO: cnt_next = '0;
            CNT_ONE:  cnt_next = IDX_W'(1);
            CNT_INC:  cnt_next = cnt_reg + 1'b1;
            default:  cnt_next = cnt_reg;
        endcase
    end

    assign gap_next = ctrl.gap_load ? ptr_reg : gap_reg;

    // Remainder of (value >> 2) by the table size, MSB first, one digit a step
    assign home_in      = ctrl.home_from_rd ? rd_data_reg : key_reg;
    assign home_shifted = home_in >> HOME_SHIFT;

    always_comb begin
        logic [REM_W-1:0] rem;
        logic [KEY_W-1:0] src;
        rem = home_rem_reg;
        src = home_src_reg;
        for (int i = 0; i < HOME_DIGIT_W; i++) begin
            rem = {rem[IDX_W-1:0], src[KEY_W-1]};
            src = src << 1;
            if (rem >= SIZE_R) begin
                rem = rem - SIZE_R;
            end
        end
        step_rem = rem;
        step_src = src;
    end

    always_comb begin
        home_src_next = home_src_reg;
        home_rem_next = home_rem_reg;
        home_cnt_next = home_cnt_reg;
        if (ctrl.home_start) begin
            if (IS_POW2) begin
                home_src_next = home_shifted;
                home_rem_next = REM_W'(home_shifted[IDX_W-1:0]);
                home_cnt_next = '0;
            end else begin
                home_src_next = home_shifted;
                home_rem_next = '0;
                home_cnt_next = HCNT_W'(HOME_STEPS);
            end
        end else if (home_cnt_reg != '0) begin
            home_src_next = step_src;
            home_rem_next = step_rem;
            home_cnt_next = home_cnt_reg - 1'b1;
        end
    end

    // An entry stays put if its home lies cyclically in (gap, j]
    always_comb begin
        if (gap_reg <= ptr_reg) begin
            stays = (gap_reg < home_val) && (home_val <= ptr_reg);
        end else begin
            stays = (gap_reg < home_val) || (home_val <= ptr_reg);
        end
    end

    always_comb begin
        wr_addr = ptr_reg;
        wr_data = '0;
        case (ctrl.wr_sel)
            WR_CLEAR: begin
                wr_addr = ptr_reg;
                wr_data = '0;
            end
            WR_INSERT: begin
                wr_addr = ptr_reg;
                wr_data = key_reg;
            end
            WR_MOVE: begin
                wr_addr = gap_reg;
                wr_data = rd_data_reg;
            end
            default: begin
                wr_addr = gap_reg;
                wr_data = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[ptr_reg];
    end

    assign slot_ext = EXT_W'(ptr_reg);

    always_comb begin
        res_next = res_reg;
        if (ctrl.res_load) begin
            res_next.slot       = ctrl.res_slot_ptr ? slot_ext[SLOT_W-1:0] : '0;
            res_next.found      = ctrl.res_found;
            res_next.written    = ctrl.res_written;
            res_next.table_full = ctrl.res_full;
        end
    end

    assign out_next = ctrl.out_load ? res_reg : out_reg;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (ctrl.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg       <= '0;
            home_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            ptr_reg       <= ptr_next;
            home_cnt_reg  <= home_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg      <= cnt_next;
        gap_reg      <= gap_next;
        home_src_reg <= home_src_next;
        home_rem_reg <= home_rem_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
        if (ctrl.req_load) begin
            key_reg <= s_data.key;
            cmd_reg <= s_data.cmd;
        end
    end

    assign status.clear_last = (ptr_reg == LAST_IDX);
    assign status.key_zero   = (key_reg == '0);
    assign status.is_insert  = (cmd_reg == CMD_INSERT);
    assign status.is_erase   = (cmd_reg == CMD_ERASE);
    assign status.home_done  = (home_cnt_reg == '0);
    assign status.match      = (rd_data_reg == key_reg);
    assign status.empty      = (rd_data_reg == '0);
    assign status.cnt_last   = (cnt_reg == LAST_IDX);
    assign status.stays      = stays;
    assign status.out_busy   = out_valid_reg && !m_ready;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule
`default_nettype wire

// ===== rtl/lph_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lph_ctrl
// Sequencer for the hash table: store clear after reset, home-slot
// computation, linear probe, insert, erase with backward-shift gap closing.
// ----------------------------------------------------------------------------
module lph_ctrl
    import lph_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire lph_status_t status,
    output lph_ctrl_t        ctrl
);

    lph_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (status.clear_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) state_next = ST_START;
            end
            ST_START: begin
                state_next = status.key_zero ? ST_DONE : ST_HOME;
            end
            ST_HOME: begin
                if (status.home_done) state_next = ST_PRD;
            end
            ST_PRD: begin
                state_next = ST_PCMP;
            end
            ST_PCMP: begin
                if (status.match) begin
                    state_next = status.is_erase ? ST_GRD : ST_DONE;
                end else if (status.empty || status.cnt_last) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_PRD;
                end
            end
            ST_GRD: begin
                state_next = ST_GCHK;
            end
            ST_GCHK: begin
                state_next = status.empty ? ST_GEND : ST_GHOME;
            end
            ST_GHOME: begin
                if (status.home_done) begin
                    state_next = status.cnt_last ? ST_GEND : ST_GRD;
                end
            end
            ST_GEND: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!status.out_busy) state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        s_ready           = 1'b0;
        ctrl.ptr_op       = PTR_HOLD;
        ctrl.cnt_op       = CNT_HOLD;
        ctrl.gap_load     = 1'b0;
        ctrl.home_start   = 1'b0;
        ctrl.home_from_rd = 1'b0;
        ctrl.req_load     = 1'b0;
        ctrl.wr_en        = 1'b0;
        ctrl.wr_sel       = WR_CLEAR;
        ctrl.res_load     = 1'b0;
        ctrl.res_slot_ptr = 1'b0;
        ctrl.res_found    = 1'b0;
        ctrl.res_written  = 1'b0;
        ctrl.res_full     = 1'b0;
        ctrl.out_load     = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                ctrl.wr_en  = 1'b1;
                ctrl.wr_sel = WR_CLEAR;
                if (!status.clear_last) ctrl.ptr_op = PTR_INC;
            end
            ST_IDLE: begin
                s_ready       = 1'b1;
                ctrl.req_load = s_valid;
            end
            ST_START: begin
                // zero key marks an empty slot: answer without probing
                if (status.key_zero) begin
                    ctrl.res_load = 1'b1;
                end else begin
                    ctrl.home_start = 1'b1;
                end
            end
            ST_HOME: begin
                if (status.home_done) begin
                    ctrl.ptr_op = PTR_HOME;
                    ctrl.cnt_op = CNT_ZERO;
                end
            end
            ST_PRD: begin
            end
            ST_PCMP: begin
                if (status.match) begin
                    ctrl.res_load     = 1'b1;
                    ctrl.res_slot_ptr = 1'b1;
                    ctrl.res_found    = 1'b1;
                    ctrl.res_written  = status.is_erase;
                    if (status.is_erase) begin
                        ctrl.gap_load = 1'b1;
                        ctrl.ptr_op   = PTR_INC;
                        ctrl.cnt_op   = CNT_ONE;
                    end
                end else if (status.empty) begin
                    ctrl.res_load     = 1'b1;
                    ctrl.res_slot_ptr = 1'b1;
                    ctrl.res_written  = status.is_insert;
                    ctrl.wr_en        = status.is_insert;
                    ctrl.wr_sel       = WR_INSERT;
                end else if (status.cnt_last) begin
                    ctrl.res_load = 1'b1;
                    ctrl.res_full = 1'b1;
                end else begin
                    ctrl.ptr_op = PTR_INC;
                    ctrl.cnt_op = CNT_INC;
                end
            end
            ST_GRD: begin
            end
            ST_GCHK: begin
                if (!status.empty) begin
                    ctrl.home_start   = 1'b1;
                    ctrl.home_from_rd = 1'b1;
                end
            end
            ST_GHOME: begin
                if (status.home_done) begin
                    // pull the entry back into the gap
                    if (!status.stays) begin
                        ctrl.wr_en    = 1'b1;
                        ctrl.wr_sel   = WR_MOVE;
                        ctrl.gap_load = 1'b1;
                    end
                    if (!status.cnt_last) begin
                        ctrl.ptr_op = PTR_INC;
                        ctrl.cnt_op = CNT_INC;
                    end
                end
            end
            ST_GEND: begin
                ctrl.wr_en  = 1'b1;
                ctrl.wr_sel = WR_SHUT;
            end
            ST_DONE: begin
                ctrl.out_load = !status.out_busy;
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/linear_probe_hash_table_core.sv =====
`default_nettype none
// A request computes the home slot, then probes slot by slot from there;
//   a table size that is not a power of two adds remainder steps to every home.
// Erase then visits each filled slot behind the cleared one until an empty slot or a full
//   turn of the table ends the scan, and clears the final gap.
// One request at a time; the next can be taken in the cycle after its result loads.
// Reset: synchronous, active low; the store is then cleared slot by slot.
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core
// Open-addressing hash table of nonzero keys with linear probing: lookup,
// insert if absent and erase with backward-shift deletion.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_core
    import lph_pkg::*;
#(
    parameter int TABLE_SIZE = 64
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire lph_in_t s_data,
    output logic         m_valid,
    input  wire logic    m_ready,
    output lph_out_t     m_data
);

    lph_ctrl_t   ctrl;
    lph_status_t status;

    lph_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .ctrl    (ctrl)
    );

    lph_dpath #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .status  (status),
        .s_data  (s_data),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire
